// ===== hw/rtl/bmalu_pkg.sv =====
package bmalu_pkg;

  localparam logic [2:0] ACT_UNARY = 3'd0;
  localparam logic [2:0] ACT_COMPL = 3'd1;
  localparam logic [2:0] ACT_REG   = 3'd4;

  localparam logic [2:0] F3_CLZ   = 3'd0;
  localparam logic [2:0] F3_CTZ   = 3'd1;
  localparam logic [2:0] F3_PCNT  = 3'd2;
  localparam logic [2:0] F3_SLOI  = 3'd3;
  localparam logic [2:0] F3_SROI  = 3'd4;
  localparam logic [2:0] F3_GREVI = 3'd5;
  localparam logic [2:0] F3_GZIP  = 3'd6;

  localparam logic [2:0] F3_ANDC = 3'd0;
  localparam logic [2:0] F3_SRO  = 3'd1;
  localparam logic [2:0] F3_SLO  = 3'd2;
  localparam logic [2:0] F3_GREV = 3'd3;
  localparam logic [2:0] F3_BEXT = 3'd4;
  localparam logic [2:0] F3_BDEP = 3'd5;

  localparam logic [2:0] F3_CMISC = 3'd3;

  localparam logic [1:0] V_NEG   = 2'd0;
  localparam logic [1:0] V_NOT   = 2'd1;
  localparam logic [1:0] V_BREV  = 2'd2;
  localparam logic [1:0] V_ONES  = 2'd2;
  localparam logic [1:0] V_ROT   = 2'd3;

  localparam logic [31:0] ZERO_COUNT = 32'd64;

  function automatic logic [31:0] grev(input logic [31:0] x_in, input logic [4:0] k);
    logic [31:0] x;
    x = x_in;
    if (k[0]) x = ((x & 32'h55555555) << 1)  | ((x & 32'hAAAAAAAA) >> 1);
    if (k[1]) x = ((x & 32'h33333333) << 2)  | ((x & 32'hCCCCCCCC) >> 2);
    if (k[2]) x = ((x & 32'h0F0F0F0F) << 4)  | ((x & 32'hF0F0F0F0) >> 4);
    if (k[3]) x = ((x & 32'h00FF00FF) << 8)  | ((x & 32'hFF00FF00) >> 8);
    if (k[4]) x = ((x & 32'h0000FFFF) << 16) | ((x & 32'hFFFF0000) >> 16);
    return x;
  endfunction

  function automatic logic [31:0] zip_stage(input logic [31:0] x, input logic [31:0] keep,
                                            input logic [31:0] lmask,
                                            input logic [31:0] rmask, input int unsigned s);
    return (x & keep) | ((x << s) & lmask) | ((x >> s) & rmask);
  endfunction

  function automatic logic [31:0] gzip(input logic [31:0] x_in, input logic [4:0] k);
    logic [31:0] x;
    x = x_in;
    if (k[0]) begin
      if (k[1]) x = zip_stage(x, 32'h99999999, 32'h44444444, 32'h22222222, 1);
      if (k[2]) x = zip_stage(x, 32'hC3C3C3C3, 32'h30303030, 32'h0C0C0C0C, 2);
      if (k[3]) x = zip_stage(x, 32'hF00FF00F, 32'h0F000F00, 32'h00F000F0, 4);
      if (k[4]) x = zip_stage(x, 32'hFF0000FF, 32'h00FF0000, 32'h0000FF00, 8);
    end else begin
      if (k[4]) x = zip_stage(x, 32'hFF0000FF, 32'h00FF0000, 32'h0000FF00, 8);
      if (k[3]) x = zip_stage(x, 32'hF00FF00F, 32'h0F000F00, 32'h00F000F0, 4);
      if (k[2]) x = zip_stage(x, 32'hC3C3C3C3, 32'h30303030, 32'h0C0C0C0C, 2);
      if (k[1]) x = zip_stage(x, 32'h99999999, 32'h44444444, 32'h22222222, 1);
    end
    return x;
  endfunction

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] w;
    w = {x, x} >> k;
    return w[31:0];
  endfunction

  function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [4:0] k);
    logic [63:0] w;
    w = {x, x} << k;
    return w[63:32];
  endfunction

endpackage

// ===== hw/rtl/bit_manipulation_alu_unit.sv =====
// Bit-manipulation ALU, 32-bit, one operation per item.
// Command channel: action, funct3, imm, rs1 and rs2 are taken at a rising
// clock edge at which start is high and busy is low. Busy is always low, so
// a new item may be started in every cycle.
// Result channel: result is valid for exactly one cycle while done is high.
// An item taken with start passes the input register and then the result
// register, where done rises together with its result; the throughput is one
// item per cycle.
// The operands go into an input register, the operation is decoded and
// computed in one pass of logic, and the word goes into the result register.
// Bit extract and deposit use per-bit prefix counts of the mask, which set
// the longest path of that pass.
// Reset (rst, synchronous) clears the pipeline valid bits, so no result
// appears for items started before reset.
// The receiver cannot stall: each result must be taken in its done cycle.
module bit_manipulation_alu_unit
  import bmalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [2:0]  funct3,
  input  logic [11:0] imm,
  input  logic [31:0] rs1,
  input  logic [31:0] rs2,
  output logic        done,
  output logic [31:0] result
);

  logic        in_valid;
  logic [2:0]  act_r;
  logic [2:0]  f3_r;
  logic [11:0] imm_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] result_next;

  logic [1:0]  v;
  logic [4:0]  ia;
  logic [4:0]  ra;
  logic [31:0] clz_val;
  logic [31:0] ctz_val;
  logic [31:0] pcnt_val;
  logic [4:0]  pre [32];
  logic [31:0] bext_val;
  logic [31:0] bdep_val;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
    if (start) begin
      act_r <= action;
      f3_r  <= funct3;
      imm_r <= imm;
      a_r   <= rs1;
      b_r   <= rs2;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  assign v  = imm_r[11:10];
  assign ia = imm_r[4:0];
  assign ra = b_r[4:0];

  always_comb begin
    clz_val = ZERO_COUNT;
    for (int i = 0; i < 32; i++) begin
      if (a_r[i]) clz_val = 32'(31 - i);
    end
    ctz_val = ZERO_COUNT;
    for (int i = 31; i >= 0; i--) begin
      if (a_r[i]) ctz_val = 32'(i);
    end
    pcnt_val = 32'($countones(a_r));
  end

  // Each mask bit's position among the set mask bits below it.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      pre[i] = 5'($countones(b_r & 32'((33'd1 << i) - 33'd1)));
    end
  end

  always_comb begin
    bext_val = '0;
    bdep_val = '0;
    for (int i = 0; i < 32; i++) begin
      bdep_val[i] = b_r[i] & a_r[pre[i]];
      for (int j = 0; j < 32; j++) begin
        if (b_r[i] && a_r[i] && (pre[i] == 5'(j))) bext_val[j] = 1'b1;
      end
    end
  end

  always_comb begin
    result_next = '0;
    case (act_r)
      ACT_COMPL: begin
        if (f3_r == F3_CMISC) begin
          case (v)
            V_NEG:   result_next = (~a_r) + 32'd1;
            V_NOT:   result_next = ~a_r;
            V_BREV:  result_next = grev(a_r, 5'd31);
            default: result_next = '0;
          endcase
        end
      end
      ACT_UNARY: begin
        case (f3_r)
          F3_CLZ:   result_next = clz_val;
          F3_CTZ:   result_next = ctz_val;
          F3_PCNT:  result_next = pcnt_val;
          F3_SLOI: begin
            if (v == V_ONES) result_next = ~((~a_r) << ia);
            else if (v == V_ROT) result_next = rot_right(a_r, ia);
          end
          F3_SROI: begin
            if (v == V_ONES) result_next = ~((~a_r) >> ia);
          end
          F3_GREVI: result_next = grev(a_r, ia);
          F3_GZIP:  result_next = gzip(a_r, ra);
          default:  result_next = '0;
        endcase
      end
      ACT_REG: begin
        case (f3_r)
          F3_ANDC: result_next = a_r & ~b_r;
          F3_SRO: begin
            if (v == V_ONES) result_next = ~((~a_r) >> ra);
            else if (v == V_ROT) result_next = rot_right(a_r, ra);
          end
          F3_SLO: begin
            if (v == V_ONES) result_next = ~((~a_r) << ra);
            else if (v == V_ROT) result_next = rot_left(a_r, ra);
          end
          F3_GREV: result_next = grev(a_r, ra);
          F3_BEXT: result_next = bext_val;
          F3_BDEP: result_next = bdep_val;
          default: result_next = '0;
        endcase
      end
      default: result_next = '0;
    endcase
  end

`ifndef SYNTH
  // Every result belongs to an item that was started.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(start, 2))
    else $error("result without a started item");

  // Every started item gives a result.
  assert property (@(posedge clk) disable iff (rst) start |=> ##1 done)
    else $error("started item produced no result");

  // Counting operations never give more than the zero-input code.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && act_r == ACT_UNARY &&
     (f3_r == F3_CLZ || f3_r == F3_CTZ || f3_r == F3_PCNT)) |=> (result <= ZERO_COUNT))
    else $error("count result out of range");
`endif

endmodule
